/* hw/rtl/pidc_pkg.sv */
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, register codes and saturation helper for the PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

    // register file geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D   = 3'd4;

    // control law codes, bit 1 set selects the incremental form
    localparam logic [1:0] MODE_POS     = 2'd0;
    localparam logic [1:0] MODE_PI      = 2'd1;
    localparam logic [1:0] MODE_INC     = 2'd2;
    localparam logic [1:0] MODE_INC_ALT = 2'd3;

    // reset values of the registers
    localparam logic [1:0]         RST_MODE     = MODE_POS;
    localparam logic signed [15:0] RST_SETPOINT = 16'sd70;
    localparam logic signed [23:0] RST_GAIN_P   = 24'sd98304;
    localparam logic signed [23:0] RST_GAIN_I   = 24'sd7;
    localparam logic signed [23:0] RST_GAIN_D   = 24'sd327680;

    // width of the value handed to the 32-bit saturation
    localparam int SAT_W = 43;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] setpoint;
        logic signed [23:0] gain_p;
        logic signed [23:0] gain_i;
        logic signed [23:0] gain_d;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] err_sum;
        logic signed [16:0] err_prev;
        logic signed [16:0] err_prev2;
        logic signed [31:0] accum;
    } t_state;

    typedef struct packed {
        logic signed [31:0] val;
        logic               hit;
    } t_sat;

    // clamp a wide signed value to the 32-bit signed range
    function automatic t_sat sat32(input logic signed [SAT_W-1:0] v);
        t_sat r;
        r.hit = (v[SAT_W-1:31] != {(SAT_W-31){v[31]}});
        if (!r.hit) begin
            r.val = v[31:0];
        end else if (v[SAT_W-1]) begin
            r.val = {1'b1, {31{1'b0}}};
        end else begin
            r.val = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pidc_cfg.sv */
// ----------------------------------------------------------------------------
// pidc_cfg
// Control register file: mode, setpoint and the three Q8.16 gains.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pidc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output pidc_pkg::t_cfg                       o_cfg
);
    import pidc_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= RST_MODE;
            r_cfg.setpoint <= RST_SETPOINT;
            r_cfg.gain_p   <= RST_GAIN_P;
            r_cfg.gain_i   <= RST_GAIN_I;
            r_cfg.gain_d   <= RST_GAIN_D;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MODE:     r_cfg.mode     <= i_cfg_wdata[1:0];
                REG_SETPOINT: r_cfg.setpoint <= $signed(i_cfg_wdata[15:0]);
                REG_GAIN_P:   r_cfg.gain_p   <= $signed(i_cfg_wdata);
                REG_GAIN_I:   r_cfg.gain_i   <= $signed(i_cfg_wdata);
                REG_GAIN_D:   r_cfg.gain_d   <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/pidc_core.sv */
// ----------------------------------------------------------------------------
// pidc_core
// One control step: error, history update, three gain products, Q16 shift
// and saturation for the positional, PI and incremental laws.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_core (
    input  wire pidc_pkg::t_cfg     i_cfg,
    input  wire pidc_pkg::t_state   i_state,
    input  wire logic signed [15:0] i_measured,
    output pidc_pkg::t_state        o_state,
    output logic signed [31:0]      o_drive,
    output logic                    o_saturated
);
    import pidc_pkg::*;

    logic               w_inc;
    logic               w_use_d;
    logic signed [16:0] w_err;
    logic signed [17:0] w_diff1;
    logic signed [18:0] w_diff2;
    logic signed [32:0] w_sum_wide;
    t_sat               w_sum_sat;
    logic signed [31:0] w_opb;
    logic signed [17:0] w_opc;
    logic signed [40:0] w_prod_p;
    logic signed [55:0] w_prod_i;
    logic signed [41:0] w_prod_d;
    logic signed [57:0] w_acc;
    logic signed [41:0] w_shifted;
    t_sat               w_out_sat;

    // mode decode
    always_comb begin
        w_inc   = 1'b0;
        w_use_d = 1'b0;
        unique case (i_cfg.mode) inside
            MODE_POS:               w_use_d = 1'b1;
            MODE_PI:                w_use_d = 1'b0;
            MODE_INC, MODE_INC_ALT: begin
                w_inc   = 1'b1;
                w_use_d = 1'b1;
            end
        endcase
    end

    // error and its differences
    assign w_err   = $signed({i_cfg.setpoint[15], i_cfg.setpoint})
                   - $signed({i_measured[15], i_measured});
    assign w_diff1 = 18'(w_err) - 18'(i_state.err_prev);
    assign w_diff2 = 19'(w_err) - (19'(i_state.err_prev) <<< 1) + 19'(i_state.err_prev2);

    // running error sum with clamp
    assign w_sum_wide = 33'(i_state.err_sum) + 33'(w_err);
    assign w_sum_sat  = sat32(SAT_W'(w_sum_wide));

    // operand selection for the shared multipliers
    assign w_opb = w_inc ? 32'(w_diff2) : w_sum_sat.val;
    assign w_opc = w_use_d ? w_diff1 : 18'sd0;

    // gain products and their exact sum
    assign w_prod_p = 41'(i_cfg.gain_p) * 41'(w_err);
    assign w_prod_i = 56'(i_cfg.gain_i) * 56'(w_opb);
    assign w_prod_d = 42'(i_cfg.gain_d) * 42'(w_opc);
    assign w_acc    = 58'(w_prod_p) + 58'(w_prod_i) + 58'(w_prod_d);

    // arithmetic shift by 16 rounds toward minus infinity
    assign w_shifted = $signed(w_acc[57:16]);

    // output clamp, incremental form adds onto the accumulator
    always_comb begin
        if (w_inc) begin
            w_out_sat = sat32(SAT_W'(i_state.accum) + SAT_W'(w_shifted));
        end else begin
            w_out_sat = sat32(SAT_W'(w_shifted));
        end
    end

    // history update per control law
    always_comb begin
        o_state = i_state;
        if (w_inc) begin
            o_state.accum     = w_out_sat.val;
            o_state.err_prev2 = i_state.err_prev;
            o_state.err_prev  = w_err;
        end else begin
            o_state.err_sum = w_sum_sat.val;
            if (w_use_d) begin
                o_state.err_prev = w_err;
            end
        end
    end

    assign o_drive     = w_out_sat.val;
    assign o_saturated = w_out_sat.hit | (!w_inc & w_sum_sat.hit);

endmodule

`default_nettype wire

/* hw/rtl/pid_controller_three_mode.sv */
// ----------------------------------------------------------------------------
// pid_controller_three_mode: input register, combinational control step, then
// result register; one request per cycle sustained while the output is not stalled.
// Synchronous active-low reset clears history and pipeline valids and loads register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_three_mode (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pidc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // [15:0] measured
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [31:0]                          m_axis_tdata,  // [31:0] drive
    output logic [0:0]                           m_axis_tuser   // [0] saturated
);
    import pidc_pkg::*;

    t_cfg               w_cfg;
    t_state             r_state;
    t_state             n_state;
    logic               r_in_valid;
    logic signed [15:0] r_in_meas;
    logic               r_out_valid;
    logic signed [31:0] r_drive;
    logic               r_sat;
    logic signed [31:0] n_drive;
    logic               n_sat;
    logic               w_advance;
    logic               w_in_take;

    pidc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pidc_core u_core (
        .i_cfg       (w_cfg),
        .i_state     (r_state),
        .i_measured  (r_in_meas),
        .o_state     (n_state),
        .o_drive     (n_drive),
        .o_saturated (n_sat)
    );

    // pipeline flow control
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_meas <= $signed(s_axis_tdata);
        end
    end

    // controller history, moves only with a completed step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_drive <= n_drive;
            r_sat   <= n_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_drive;
    assign m_axis_tuser  = r_sat;

    // a completed step always leaves a result
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("control step finished without a result");

    // history holds while no step completes
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state))
        else $error("controller history changed without a step");

    // incremental form never touches the error sum
    a_inc_keeps_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_cfg.mode[1]) |=> $stable(r_state.err_sum))
        else $error("error sum changed in incremental mode");

endmodule

`default_nettype wire

/* test/tb_pid_controller_three_mode.sv */
// ----------------------------------------------------------------------------
// tb_pid_controller_three_mode
// Self-checking bench for the three-mode fixed-point PID controller. Sample
// requests go in on the input stream and every accepted sample is run through
// a local copy of the control law (positional, PI, incremental) to get the
// expected drive and saturation flag. Results are matched in order on the
// output stream. A short directed table comes first, then random phases with
// fresh register settings, then runs at full error: PI, then incremental to
// drive the output accumulator to its limits, then positional with a large integral gain.
// ----------------------------------------------------------------------------

module tb_pid_controller_three_mode;

    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    // run control
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int N_PHASES       = 12;
    localparam int PHASE_SAMPLES  = 80;
    localparam int TAIL_CYCLES    = 8;

    // indexes that decode to no register
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_MID = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI  = 3'd7;

    // 32-bit signed limits
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    // input field extremes and gain extremes
    localparam logic signed [15:0] MEAS_MAX = 16'sh7fff;
    localparam logic signed [15:0] MEAS_MIN = 16'sh8000;
    localparam logic [23:0]        GAIN_MAX = 24'h7fffff;
    localparam logic [23:0]        GAIN_MIN = 24'h800000;
    localparam logic [23:0]        GAIN_ONE = 24'h010000;

    typedef struct {
        logic signed [31:0] drive;
        logic               sat;
    } t_drive_exp;

    typedef enum bit {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_ADDR_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]  val;
        logic signed [15:0]     meas;
        bit                     typed;
        logic signed [31:0]     drive;
        bit                     sat;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;   // [15:0] measured
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;         // [31:0] drive
    logic [0:0]            m_axis_tuser;         // [0] saturated

    // register shadow
    logic [1:0]         pid_mode;
    logic signed [15:0] pid_setpoint;
    logic signed [23:0] pid_kp;
    logic signed [23:0] pid_ki;
    logic signed [23:0] pid_kd;

    // controller history
    logic signed [31:0] pid_err_sum;
    logic signed [16:0] pid_err_prev;
    logic signed [16:0] pid_err_prev2;
    logic signed [31:0] pid_accum;

    t_drive_exp drive_pending[$];
    t_row       plan[$];
    int         n_fail      = 0;
    int         cycle_count = 0;
    bit         steady      = 1'b0;
    bit         rx_hold_req = 1'b0;

    pid_controller_three_mode i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // random gap, about 6 in 100 outside steady stretches
    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 6);
    endfunction

    // clamp to 32-bit signed, flag when clipped
    function automatic logic signed [31:0] clamp32(input longint v, output bit hit);
        hit = 1'b0;
        if (v > S32_HI) begin
            hit = 1'b1;
            return 32'(S32_HI);
        end
        if (v < S32_LO) begin
            hit = 1'b1;
            return 32'(S32_LO);
        end
        return 32'(v);
    endfunction

    // one control tick: update history, return drive and flag
    function automatic t_drive_exp pid_tick(input logic signed [15:0] meas);
        t_drive_exp r;
        longint     e;
        longint     acc;
        bit         hit_a;
        bit         hit_b;
        hit_a = 1'b0;
        hit_b = 1'b0;
        e = longint'(pid_setpoint) - longint'(meas);
        if (pid_mode[1]) begin
            // incremental: D on first difference, P on error, I on second difference
            acc = longint'(pid_kd) * (e - longint'(pid_err_prev))
                + longint'(pid_kp) * e
                + longint'(pid_ki) * (e - 2 * longint'(pid_err_prev)
                                        + longint'(pid_err_prev2));
            pid_accum     = clamp32(longint'(pid_accum) + (acc >>> 16), hit_a);
            r.drive       = pid_accum;
            pid_err_prev2 = pid_err_prev;
            pid_err_prev  = 17'(e);
        end else begin
            pid_err_sum = clamp32(longint'(pid_err_sum) + e, hit_a);
            acc = longint'(pid_kp) * e + longint'(pid_ki) * longint'(pid_err_sum);
            if (pid_mode == MODE_POS) begin
                acc += longint'(pid_kd) * (e - longint'(pid_err_prev));
                pid_err_prev = 17'(e);
            end
            r.drive = clamp32(acc >>> 16, hit_b);
        end
        r.sat = hit_a | hit_b;
        return r;
    endfunction

    // stop offering samples and let every pending result come back
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (drive_pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // register write, only with the controller idle
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:     pid_mode     = val[1:0];
            REG_SETPOINT: pid_setpoint = val[15:0];
            REG_GAIN_P:   pid_kp       = val;
            REG_GAIN_I:   pid_ki       = val;
            REG_GAIN_D:   pid_kd       = val;
            default: ;
        endcase
    endtask

    // offer one sample request, record its expected result once accepted
    task automatic send_sample(input logic signed [15:0] meas, input bit typed,
                               input logic signed [31:0] drive, input bit sat);
        t_drive_exp x;
        while (take_gap()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= meas;
        do @(posedge i_clk); while (!s_axis_tready);
        x = pid_tick(meas);
        if (typed) begin
            x.drive = drive;
            x.sat   = sat;
        end
        drive_pending.push_back(x);
    endtask

    function automatic t_row wr_row(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_row r;
        r = '{ROW_WRITE, idx, val, 16'sd0, 1'b0, 32'sd0, 1'b0};
        return r;
    endfunction

    function automatic t_row smp_row(input logic signed [15:0] meas, input bit typed,
                                     input logic signed [31:0] drive, input bit sat);
        t_row r;
        r = '{ROW_SAMPLE, '0, '0, meas, typed, drive, sat};
        return r;
    endfunction

    // gain draw weighted toward zero and the extremes
    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return GAIN_MIN;
            3:       return 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return 24'($urandom);
        endcase
    endfunction

    // result side: random back-pressure plus one long hold-off on request
    initial begin : sink
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= !take_gap();
            end
        end
    end

    // in-order compare of every accepted result
    always @(posedge i_clk) begin : check
        t_drive_exp x;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_pending.size() == 0) begin
                $error("drive result with no request pending: drive %0d saturated %0d",
                       $signed(m_axis_tdata), m_axis_tuser[0]);
                n_fail++;
            end else begin
                x = drive_pending.pop_front();
                if (m_axis_tdata !== x.drive) begin
                    $error("drive: expected %0d, got %0d", x.drive, $signed(m_axis_tdata));
                    n_fail++;
                end
                if (m_axis_tuser[0] !== x.sat) begin
                    $error("saturated: expected %0d, got %0d", x.sat, m_axis_tuser[0]);
                    n_fail++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row               r;
        int                 ph;
        int                 n;
        int                 prof;
        int                 v;
        logic signed [15:0] m;

        // directed table: reset values, every mode, ignored indexes, extremes
        plan.push_back(smp_row(16'sd70, 1'b1, 32'sd0, 1'b0));
        plan.push_back(smp_row(16'sd69, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(MEAS_MIN, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(MEAS_MAX, 1'b0, 32'sd0, 1'b0));
        plan.push_back(wr_row(REG_MODE, 24'(MODE_PI)));
        plan.push_back(smp_row(16'sd0, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(MEAS_MAX, 1'b0, 32'sd0, 1'b0));
        plan.push_back(wr_row(REG_MODE, 24'(MODE_INC)));
        plan.push_back(smp_row(MEAS_MIN, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(16'sd70, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(MEAS_MAX, 1'b0, 32'sd0, 1'b0));
        plan.push_back(wr_row(REG_MODE, 24'(MODE_INC_ALT)));
        plan.push_back(smp_row(16'sd1234, 1'b0, 32'sd0, 1'b0));
        // writes to unused indexes must not alias onto real registers
        plan.push_back(wr_row(REG_UNUSED_LO, 24'hffffff));
        plan.push_back(wr_row(REG_UNUSED_MID, 24'h5a5a5a));
        plan.push_back(wr_row(REG_UNUSED_HI, 24'h000000));
        plan.push_back(smp_row(16'sd70, 1'b0, 32'sd0, 1'b0));
        plan.push_back(wr_row(REG_SETPOINT, 24'h007fff));
        plan.push_back(wr_row(REG_GAIN_P, GAIN_MAX));
        plan.push_back(wr_row(REG_GAIN_I, GAIN_MIN));
        plan.push_back(wr_row(REG_GAIN_D, GAIN_MIN));
        plan.push_back(wr_row(REG_MODE, 24'(MODE_POS)));
        plan.push_back(smp_row(MEAS_MIN, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(MEAS_MAX, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(MEAS_MIN, 1'b0, 32'sd0, 1'b0));
        plan.push_back(wr_row(REG_SETPOINT, 24'h008000));
        plan.push_back(wr_row(REG_MODE, 24'(MODE_INC)));
        plan.push_back(smp_row(MEAS_MAX, 1'b0, 32'sd0, 1'b0));
        plan.push_back(smp_row(MEAS_MIN, 1'b0, 32'sd0, 1'b0));
        // unity proportional gain only: drive equals the error
        plan.push_back(wr_row(REG_GAIN_P, GAIN_ONE));
        plan.push_back(wr_row(REG_GAIN_I, 24'h000000));
        plan.push_back(wr_row(REG_GAIN_D, 24'h000000));
        plan.push_back(wr_row(REG_SETPOINT, 24'h000000));
        plan.push_back(wr_row(REG_MODE, 24'(MODE_PI)));
        plan.push_back(smp_row(MEAS_MIN, 1'b1, 32'sd32768, 1'b0));
        plan.push_back(smp_row(MEAS_MAX, 1'b1, -32'sd32767, 1'b0));
        plan.push_back(wr_row(REG_GAIN_P, 24'h000000));
        plan.push_back(smp_row(16'sd12345, 1'b1, 32'sd0, 1'b0));

        // reset and predictor start state
        pid_mode      = RST_MODE;
        pid_setpoint  = RST_SETPOINT;
        pid_kp        = RST_GAIN_P;
        pid_ki        = RST_GAIN_I;
        pid_kd        = RST_GAIN_D;
        pid_err_sum   = '0;
        pid_err_prev  = '0;
        pid_err_prev2 = '0;
        pid_accum     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (plan[k]) begin
            r = plan[k];
            if (r.kind == ROW_WRITE) begin
                cfg_write(r.idx, r.val);
            end else begin
                send_sample(r.meas, r.typed, r.drive, r.sat);
            end
        end

        // random phases, each with fresh settings
        for (ph = 0; ph < N_PHASES; ph++) begin
            steady = (ph == 5 || ph == 6);
            cfg_write(REG_MODE, {22'($urandom), 2'($urandom_range(0, 3))});
            case ($urandom_range(0, 3))
                0:       v = 32767;
                1:       v = -32768;
                2:       v = 0;
                default: v = $signed($urandom_range(0, 65535)) - 32768;
            endcase
            cfg_write(REG_SETPOINT, {8'($urandom), 16'(v)});
            cfg_write(REG_GAIN_P, pick_gain());
            cfg_write(REG_GAIN_I, pick_gain());
            cfg_write(REG_GAIN_D, pick_gain());
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 24'($urandom));
            end
            // long receiver hold-off while samples keep coming
            if (ph == 3) rx_hold_req = 1'b1;
            prof = $urandom_range(0, 3);
            for (n = 0; n < PHASE_SAMPLES; n++) begin
                // settling around the setpoint, full range, or rail to rail
                if (prof == 1 || (prof == 3 && $urandom_range(0, 1) == 0)) begin
                    v = int'(pid_setpoint) + $signed($urandom_range(0, 128)) - 64;
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                    m = 16'(v);
                end else if (prof == 2) begin
                    m = $urandom_range(0, 1) ? MEAS_MAX : MEAS_MIN;
                end else begin
                    m = 16'($urandom);
                end
                send_sample(m, 1'b0, 32'sd0, 1'b0);
            end
        end
        steady = 1'b0;

        // PI law at full error of both signs
        cfg_write(REG_MODE, 24'(MODE_PI));
        cfg_write(REG_GAIN_I, 24'h000100);
        cfg_write(REG_GAIN_P, pick_gain());
        cfg_write(REG_SETPOINT, 24'h008000);
        for (n = 0; n < 20; n++) send_sample(MEAS_MAX, 1'b0, 32'sd0, 1'b0);
        cfg_write(REG_SETPOINT, 24'h007fff);
        for (n = 0; n < 20; n++) send_sample(MEAS_MIN, 1'b0, 32'sd0, 1'b0);

        // output accumulator driven to both limits
        cfg_write(REG_MODE, 24'(MODE_INC));
        cfg_write(REG_GAIN_P, GAIN_MAX);
        cfg_write(REG_GAIN_I, 24'h000000);
        cfg_write(REG_GAIN_D, 24'h000000);
        for (n = 0; n < 300; n++) send_sample(MEAS_MIN, 1'b0, 32'sd0, 1'b0);
        cfg_write(REG_SETPOINT, 24'h008000);
        for (n = 0; n < 600; n++) send_sample(MEAS_MAX, 1'b0, 32'sd0, 1'b0);

        // positional law with a large integral gain
        cfg_write(REG_MODE, 24'(MODE_POS));
        cfg_write(REG_GAIN_P, 24'h000000);
        cfg_write(REG_GAIN_I, GAIN_MAX);
        for (n = 0; n < 20; n++) send_sample(16'($urandom), 1'b0, 32'sd0, 1'b0);
        cfg_write(REG_GAIN_I, GAIN_MIN);
        for (n = 0; n < 20; n++) send_sample(16'($urandom), 1'b0, 32'sd0, 1'b0);

        // drain and let any stray result show up
        s_axis_tvalid <= 1'b0;
        while (drive_pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
